/* rtl/mfmb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmb_pkg
// Shared widths, CORDIC angle table and sequencer states for the mean bearing
// block.
// ----------------------------------------------------------------------------
package mfmb_pkg;

  localparam int COORD_BITS   = 12;
  localparam int FRAC_BITS    = 8;
  localparam int CORDIC_STEPS = 16;

  localparam int CNT_W  = 25;
  localparam int SSUM_W = 36;
  localparam int ESUM_W = 46;
  localparam int QUO_W  = 46;
  localparam int DIV_W  = 46;
  localparam int DIVC_W = 6;
  localparam int CRD_W  = 34;
  localparam int ANG_W  = 32;
  localparam int STEP_W = 5;

  typedef enum logic [6:0] {
    ST_ACC  = 7'b0000001,
    ST_DIV  = 7'b0000010,
    ST_NEXT = 7'b0000100,
    ST_CPRE = 7'b0001000,
    ST_CRD  = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  function automatic logic signed [ANG_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] v;
    unique case (i)
      5'd0:  v = 32'sd2949120;
      5'd1:  v = 32'sd1740967;
      5'd2:  v = 32'sd919879;
      5'd3:  v = 32'sd466945;
      5'd4:  v = 32'sd234379;
      5'd5:  v = 32'sd117304;
      5'd6:  v = 32'sd58666;
      5'd7:  v = 32'sd29335;
      5'd8:  v = 32'sd14668;
      5'd9:  v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;
      5'd22: v = 32'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/mfmb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmb_in_if / mfmb_out_if
// Valid/ready channels for pixel beats and result beats.
// ----------------------------------------------------------------------------
interface mfmb_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [mfmb_pkg::COORD_BITS-1:0]       pixel_x;
  logic [mfmb_pkg::COORD_BITS-1:0]       pixel_y;
  logic                                  selected;
  logic signed [15:0]                    flow_dx;
  logic signed [15:0]                    flow_dy;
  logic                                  last_pixel;
  modport source (output valid, pixel_x, pixel_y, selected, flow_dx, flow_dy,
                  last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, selected, flow_dx, flow_dy,
                  last_pixel, output ready);
endinterface

interface mfmb_out_if;
  logic               valid;
  logic               ready;
  logic [19:0]        mean_start_x;
  logic [19:0]        mean_start_y;
  logic signed [21:0] mean_end_x;
  logic signed [21:0] mean_end_y;
  logic [8:0]         bearing_deg;
  logic [24:0]        pixel_count;
  logic               direction_valid;
  modport source (output valid, mean_start_x, mean_start_y, mean_end_x, mean_end_y,
                  bearing_deg, pixel_count, direction_valid, input ready);
  modport sink   (input valid, mean_start_x, mean_start_y, mean_end_x, mean_end_y,
                  bearing_deg, pixel_count, direction_valid, output ready);
endinterface

/* rtl/mfmb_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmb_div
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// ----------------------------------------------------------------------------
module mfmb_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [mfmb_pkg::DIV_W-1:0]       dividend,
  input  logic [mfmb_pkg::CNT_W-1:0]       divisor,
  output logic                             done,
  output logic [mfmb_pkg::QUO_W-1:0]       quotient
);

  logic [mfmb_pkg::DIV_W-1:0]  quo_r, quo_nxt;
  logic [mfmb_pkg::CNT_W:0]    rem_r, rem_nxt;
  logic [mfmb_pkg::DIVC_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic [mfmb_pkg::CNT_W:0]    trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[mfmb_pkg::CNT_W-1:0], quo_r[mfmb_pkg::DIV_W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = mfmb_pkg::DIVC_W'(mfmb_pkg::DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        quo_nxt = {quo_r[mfmb_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[mfmb_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == mfmb_pkg::DIVC_W'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else        busy_r <= busy_nxt;
  end

  assign done     = busy_r && (cnt_r == mfmb_pkg::DIVC_W'(1));
  assign quotient = quo_nxt;

endmodule

/* rtl/mfmb_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmb_cordic
// Vectoring CORDIC, one micro-rotation per cycle, angle in 2^-16 degree.
// ----------------------------------------------------------------------------
module mfmb_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [mfmb_pkg::CRD_W-1:0] x_in,
  input  logic signed [mfmb_pkg::CRD_W-1:0] y_in,
  output logic                              done,
  output logic signed [mfmb_pkg::ANG_W-1:0] angle
);

  logic signed [mfmb_pkg::CRD_W-1:0] x_r, x_nxt, y_r, y_nxt, xs, ys;
  logic signed [mfmb_pkg::ANG_W-1:0] z_r, z_nxt;
  logic [mfmb_pkg::STEP_W-1:0]       i_r, i_nxt;
  logic                              busy_r, busy_nxt;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r; busy_nxt = busy_r;
    if (start) begin
      if (x_in < 0) begin
        x_nxt = -x_in; y_nxt = -y_in; z_nxt = 32'sd11796480;
      end else begin
        x_nxt = x_in; y_nxt = y_in; z_nxt = '0;
      end
      i_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (y_r >= 0) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + mfmb_pkg::atan_q16(i_r);
      end else begin
        x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - mfmb_pkg::atan_q16(i_r);
      end
      i_nxt = i_r + 1'b1;
      if (i_r == mfmb_pkg::STEP_W'(mfmb_pkg::CORDIC_STEPS - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; i_r <= i_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else        busy_r <= busy_nxt;
  end

  assign done  = busy_r && (i_r == mfmb_pkg::STEP_W'(mfmb_pkg::CORDIC_STEPS - 1));
  assign angle = z_nxt;

endmodule

/* rtl/masked_flow_mean_bearing_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_flow_mean_bearing_core
// Mean start/end point of masked pixels and bearing of their motion.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one pixel beat per cycle when ready (valid/ready). Selected pixels are summed.
//   out : one result beat after each beat flagged last_pixel.
// A last beat with pixels selected runs four means through a shared
//   1-bit-per-cycle divider, then a 16-step CORDIC and a rounding step
//   before out_valid. An empty frame goes straight to the output. in_ready
//   is low meanwhile.
// The result is held in the output register until out_ready; the next frame
//   is taken once the beat has been delivered.
// Reset (rst_n low, synchronous) clears the sums and count and drops valid.
// ----------------------------------------------------------------------------
module masked_flow_mean_bearing_core (
  input  logic        clk,
  input  logic        rst_n,
  mfmb_in_if.sink     in_ch,
  mfmb_out_if.source  out_ch
);

  localparam int FB = mfmb_pkg::FRAC_BITS;

  mfmb_pkg::state_t state_r, state_nxt;

  logic [mfmb_pkg::SSUM_W-1:0]        sx_r, sy_r;
  logic signed [mfmb_pkg::ESUM_W-1:0] ex_r, ey_r;
  logic [mfmb_pkg::CNT_W-1:0]         cnt_r;
  logic [1:0]                         idx_r;
  logic signed [21:0]                 m_r [4];
  logic [8:0]                         brg_r;
  logic                               ov_r;
  logic                               u_busy, first_r;

  logic acc_fire, out_fire, div_start, div_done, crd_start, crd_done;
  logic [mfmb_pkg::DIV_W-1:0]  dvd, emag;
  logic [mfmb_pkg::QUO_W-1:0]  quo;
  logic signed [mfmb_pkg::ESUM_W-1:0] esel;
  logic signed [mfmb_pkg::ANG_W-1:0]  ang;
  logic signed [mfmb_pkg::CRD_W-1:0]  ca, cb;
  logic signed [22:0] da, db;
  logic signed [mfmb_pkg::ESUM_W-1:0] fx, fy;
  logic signed [mfmb_pkg::ANG_W:0] v;
  logic [mfmb_pkg::ANG_W-16:0] q;
  logic [15:0] r;
  logic [9:0]  qr;

  assign in_ch.ready = (state_r == mfmb_pkg::ST_ACC) && !ov_r;
  assign acc_fire = in_ch.valid && in_ch.ready;
  assign out_fire = ov_r && out_ch.ready;

  assign fx = mfmb_pkg::ESUM_W'({in_ch.pixel_x, {FB{1'b0}}}) + mfmb_pkg::ESUM_W'(in_ch.flow_dx);
  assign fy = mfmb_pkg::ESUM_W'({in_ch.pixel_y, {FB{1'b0}}}) + mfmb_pkg::ESUM_W'(in_ch.flow_dy);

  assign esel = idx_r[0] ? ey_r : ex_r;
  assign emag = esel[mfmb_pkg::ESUM_W-1] ? mfmb_pkg::DIV_W'(-esel) : mfmb_pkg::DIV_W'(esel);
  always_comb begin
    if (!idx_r[1])
      dvd = mfmb_pkg::DIV_W'({(idx_r[0] ? sy_r : sx_r), {FB{1'b0}}})
            + mfmb_pkg::DIV_W'(cnt_r >> 1);
    else
      dvd = emag + mfmb_pkg::DIV_W'(cnt_r >> 1);
  end

  assign div_start = (state_r == mfmb_pkg::ST_DIV) && !ov_r;

  mfmb_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd),
    .divisor(cnt_r), .done(div_done), .quotient(quo)
  );

  assign da = 23'(m_r[0]) - 23'(m_r[2]);
  assign db = 23'(m_r[3]) - 23'(m_r[1]);
  assign ca = mfmb_pkg::CRD_W'(da) <<< 8;
  assign cb = mfmb_pkg::CRD_W'(db) <<< 8;
  assign crd_start = (state_r == mfmb_pkg::ST_CPRE);

  mfmb_cordic u_crd (
    .clk(clk), .rst_n(rst_n), .start(crd_start), .x_in(cb), .y_in(ca),
    .done(crd_done), .angle(ang)
  );

  logic signed [mfmb_pkg::ANG_W-1:0] ang_r;

  assign v  = 33'sd23592960 - 33'(ang_r);
  assign q  = v[mfmb_pkg::ANG_W:16];
  assign r  = v[15:0];
  assign qr = 10'(q) + 10'((r > 16'h8000 || (r == 16'h8000 && q[0])) ? 1 : 0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mfmb_pkg::ST_ACC:  if (acc_fire && in_ch.last_pixel) state_nxt = mfmb_pkg::ST_NEXT;
      mfmb_pkg::ST_DIV:  state_nxt = mfmb_pkg::ST_NEXT;
      mfmb_pkg::ST_NEXT: begin
        if (cnt_r == '0)            state_nxt = mfmb_pkg::ST_OUT;
        else if (div_done || idx_r == 2'd0 && !(div_done)) begin
          if (div_done && idx_r == 2'd3) state_nxt = mfmb_pkg::ST_CPRE;
          else if (div_done)           state_nxt = mfmb_pkg::ST_DIV;
          else if (idx_r == 2'd0 && !u_busy) state_nxt = mfmb_pkg::ST_DIV;
        end
      end
      mfmb_pkg::ST_CPRE: state_nxt = mfmb_pkg::ST_CRD;
      mfmb_pkg::ST_CRD:  if (crd_done) state_nxt = mfmb_pkg::ST_FIN;
      mfmb_pkg::ST_FIN:  state_nxt = mfmb_pkg::ST_OUT;
      mfmb_pkg::ST_OUT:  if (out_fire) state_nxt = mfmb_pkg::ST_ACC;
      default:           state_nxt = mfmb_pkg::ST_ACC;
    endcase
  end

  // first pass through ST_NEXT after a last beat kicks off the divider
  assign u_busy = !first_r;

  logic signed [21:0] qs;
  assign qs = (idx_r[1] && esel[mfmb_pkg::ESUM_W-1]) ? -22'(quo) : 22'(quo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfmb_pkg::ST_ACC;
      sx_r <= '0; sy_r <= '0; ex_r <= '0; ey_r <= '0; cnt_r <= '0;
      idx_r <= '0; ov_r <= 1'b0; first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_fire) ov_r <= 1'b0;
      if (acc_fire) begin
        first_r <= 1'b1;
        idx_r <= '0;
        if (in_ch.selected && !cnt_r[mfmb_pkg::CNT_W-1]) begin
          sx_r  <= sx_r + mfmb_pkg::SSUM_W'(in_ch.pixel_x);
          sy_r  <= sy_r + mfmb_pkg::SSUM_W'(in_ch.pixel_y);
          ex_r  <= ex_r + fx;
          ey_r  <= ey_r + fy;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (state_r == mfmb_pkg::ST_NEXT && idx_r == 2'd0) first_r <= 1'b0;
      if (div_done) begin
        m_r[idx_r] <= qs;
        idx_r <= idx_r + 1'b1;
      end
      // no motion: bearing 0
      if (crd_done) ang_r <= (da == '0 && db == '0) ? 32'sd23592960 : ang;
      if (state_r == mfmb_pkg::ST_FIN) brg_r <= (qr >= 10'd360) ? 9'(qr - 10'd360) : 9'(qr);
      if (state_r == mfmb_pkg::ST_NEXT && cnt_r == '0) begin
        brg_r <= '0;
        for (int k = 0; k < 4; k++) m_r[k] <= '0;
      end
      if (state_r != mfmb_pkg::ST_OUT && state_nxt == mfmb_pkg::ST_OUT) ov_r <= 1'b1;
      if (state_r == mfmb_pkg::ST_OUT && ov_r && out_fire) begin
        sx_r <= '0; sy_r <= '0; ex_r <= '0; ey_r <= '0; cnt_r <= '0;
      end
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.mean_start_x    = 20'(m_r[0]);
  assign out_ch.mean_start_y    = 20'(m_r[1]);
  assign out_ch.mean_end_x      = m_r[2];
  assign out_ch.mean_end_y      = m_r[3];
  assign out_ch.bearing_deg     = brg_r;
  assign out_ch.pixel_count     = cnt_r;
  assign out_ch.direction_valid = (cnt_r != '0);

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mfmb_pkg::ST_ACC) |-> !in_ch.ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
  a_brg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.bearing_deg < 9'd360)) else $error("bearing range");
`endif

endmodule
